// File: rtl/scri_pkg.sv
// Shared helpers for the staircase code row interleaver.
// No dependencies; imported by every module of the block.
package scri_pkg;

    // Index width for a range of n values, never below one bit.
    function automatic int f_idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// File: rtl/scri_tap.sv
// One gather tap: row age and column for one prepend position.
// Depends on scri_pkg.
module scri_tap #(
    parameter int CLASSES   = 2,
    parameter int PERMS     = 2,
    parameter int TILE      = 2,
    parameter int MAX_DELAY = 7,
    parameter int J         = 0
) (
    input  logic [CLASSES*PERMS-1:0][scri_pkg::f_idx_w(MAX_DELAY+1)-1:0] i_delay,
    input  logic [scri_pkg::f_idx_w(TILE)-1:0]                           i_phase,
    output logic [scri_pkg::f_idx_w((1+MAX_DELAY)*TILE-1)-1:0]           o_pos,
    output logic [scri_pkg::f_idx_w(CLASSES*TILE)-1:0]                   o_col
);
    import scri_pkg::*;

    localparam int ROWBITS = CLASSES * TILE;
    localparam int Q       = (1 + MAX_DELAY) * TILE - 1;
    localparam int R       = J % ROWBITS;
    localparam int PERM    = PERMS - J / ROWBITS;
    localparam int B       = R % TILE;
    localparam int C       = R / TILE;
    localparam int CLS     = CLASSES - 1 - C;
    localparam int DI      = CLS * PERMS + PERM - 1;
    localparam int ROT_K   = ((PERM - 1) * B) % TILE;
    localparam int XW      = f_idx_w(2 * Q);
    localparam int RW      = f_idx_w(2 * TILE);
    localparam int PSW     = f_idx_w(Q);
    localparam int CW      = f_idx_w(ROWBITS);

    logic [XW-1:0] w_x;
    logic [RW-1:0] w_rot;
    logic [RW-1:0] w_rmod;

    // Age is lookback minus one, offset by Q so it stays in [0, 2Q).
    assign w_x    = XW'(i_delay[DI]) * XW'(TILE) + XW'(i_phase) + XW'(Q - B - 1);
    assign o_pos  = (w_x >= XW'(Q)) ? PSW'(w_x - XW'(Q)) : PSW'(w_x);

    assign w_rot  = RW'(i_phase) + RW'(ROT_K);
    assign w_rmod = (w_rot >= RW'(TILE)) ? (w_rot - RW'(TILE)) : w_rot;
    assign o_col  = CW'(C * TILE) + CW'(w_rmod);

endmodule

// File: rtl/scri_cell.sv
// One row cell of the history line: holds one past row and adds its bits to
// the gather bus. Depends on scri_pkg.
module scri_cell #(
    parameter int ROWBITS = 4,
    parameter int NTAPS   = 8,
    parameter int PSW     = 4,
    parameter int K       = 0
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_shift,
    input  logic [ROWBITS-1:0]                               i_row,
    output logic [ROWBITS-1:0]                               o_row,
    input  logic [NTAPS-1:0][PSW-1:0]                        i_pos,
    input  logic [NTAPS-1:0][scri_pkg::f_idx_w(ROWBITS)-1:0] i_col,
    input  logic [NTAPS-1:0]                                 i_gather,
    output logic [NTAPS-1:0]                                 o_gather
);
    import scri_pkg::*;

    logic [ROWBITS-1:0] r_row;
    logic [ROWBITS-1:0] n_row;

    assign n_row = i_shift ? i_row : r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

    // Pass the bus on, adding the selected bit where a tap points here.
    always_comb begin
        for (int t = 0; t < NTAPS; t++) begin
            o_gather[t] = i_gather[t] | ((i_pos[t] == PSW'(K)) & r_row[i_col[t]]);
        end
    end

endmodule

// File: rtl/staircase_code_row_interleaver.sv
// Top level of the staircase code row interleaver: history line of row cells,
// gather taps, delay registers and output register. Depends on scri_pkg,
// scri_tap and scri_cell.
//
//   channel  direction  handshake                  payload
//   input    in         i_in_valid / o_in_ready    i_new_row_bits
//   result   out        o_out_valid / i_out_ready  o_prepend_bits, o_row_phase_out
//   config   in         i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// One row per cycle while the output slot is free or emptied: a row transfer
// gathers from the cell line in the same cycle and registers its result.
// The gather bus runs through all Q cells, which sets the longest path.
// Reset clears every cell, the phase and the output valid; delays take their
// reset values. A stalled result holds the output register and blocks input
// only while the result is not being taken in the same cycle.
module staircase_code_row_interleaver #(
    parameter int CLASSES   = 2,
    parameter int PERMS     = 2,
    parameter int TILE      = 2,
    parameter int MAX_DELAY = 7
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  logic [CLASSES*TILE-1:0]                      i_new_row_bits,
    output logic                                         o_out_valid,
    input  logic                                         i_out_ready,
    output logic [PERMS*CLASSES*TILE-1:0]                o_prepend_bits,
    output logic [scri_pkg::f_idx_w(TILE)-1:0]           o_row_phase_out,
    input  logic                                         i_cfg_wr_en,
    input  logic [scri_pkg::f_idx_w(CLASSES*PERMS)-1:0]  i_cfg_index,
    input  logic [scri_pkg::f_idx_w(MAX_DELAY+1)-1:0]    i_cfg_wdata
);
    import scri_pkg::*;

    localparam int ROWBITS = CLASSES * TILE;
    localparam int NTAPS   = PERMS * ROWBITS;
    localparam int NREGS   = CLASSES * PERMS;
    localparam int Q       = (1 + MAX_DELAY) * TILE - 1;
    localparam int DW      = f_idx_w(MAX_DELAY + 1);
    localparam int PW      = f_idx_w(TILE);
    localparam int PSW     = f_idx_w(Q);
    localparam int CW      = f_idx_w(ROWBITS);
    localparam int IW      = f_idx_w(NREGS);
    localparam int DELAY_RST [4] = '{2, 7, 3, 4};

    // Delay registers, one per class and permutation.
    logic [NREGS-1:0][DW-1:0] r_delay;
    logic [NREGS-1:0][DW-1:0] n_delay;

    // Row phase and output register.
    logic [PW-1:0]    r_phase;
    logic [PW-1:0]    n_phase;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [NTAPS-1:0] r_prepend;
    logic [NTAPS-1:0] n_prepend;
    logic [PW-1:0]    r_phase_out;
    logic [PW-1:0]    n_phase_out;

    logic             w_accept;

    // Tap results and the cell line.
    logic [NTAPS-1:0][PSW-1:0] w_pos;
    logic [NTAPS-1:0][CW-1:0]  w_col;
    logic [ROWBITS-1:0]        w_row    [Q+1];
    logic [NTAPS-1:0]          w_gather [Q+1];

    // Accept a row whenever the output slot is free or is emptied this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Configuration writes; drop indexes beyond the register list.
    always_comb begin
        n_delay = r_delay;
        for (int k = 0; k < NREGS; k++) begin
            if (i_cfg_wr_en && (i_cfg_index == IW'(k))) begin
                n_delay[k] = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREGS; k++) begin
                r_delay[k] <= DW'(DELAY_RST[k % 4]);
            end
        end else begin
            r_delay <= n_delay;
        end
    end

    // One tap per prepend position: row age and column for the current phase.
    for (genvar j = 0; j < NTAPS; j++) begin : g_tap
        scri_tap #(
            .CLASSES   (CLASSES),
            .PERMS     (PERMS),
            .TILE      (TILE),
            .MAX_DELAY (MAX_DELAY),
            .J         (j)
        ) u_tap (
            .i_delay (r_delay),
            .i_phase (r_phase),
            .o_pos   (w_pos[j]),
            .o_col   (w_col[j])
        );
    end

    // Cell k holds the row of age k (cell 0 is the newest). On a transfer the
    // line shifts by one, the new row enters cell 0 and the oldest falls off.
    assign w_row[0]    = i_new_row_bits;
    assign w_gather[0] = '0;

    for (genvar k = 0; k < Q; k++) begin : g_cell
        scri_cell #(
            .ROWBITS (ROWBITS),
            .NTAPS   (NTAPS),
            .PSW     (PSW),
            .K       (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_accept),
            .i_row    (w_row[k]),
            .o_row    (w_row[k+1]),
            .i_pos    (w_pos),
            .i_col    (w_col),
            .i_gather (w_gather[k]),
            .o_gather (w_gather[k+1])
        );
    end

    // Capture the gathered bits before the shift lands; advance the phase.
    always_comb begin
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_prepend   = r_prepend;
        n_phase_out = r_phase_out;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_prepend   = w_gather[Q];
            n_phase_out = r_phase;
            n_phase     = (r_phase == PW'(TILE - 1)) ? '0 : (r_phase + PW'(1));
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload of the output register needs no reset.
    always_ff @(posedge i_clk) begin
        r_prepend   <= n_prepend;
        r_phase_out <= n_phase_out;
    end

    assign o_out_valid     = r_out_valid;
    assign o_prepend_bits  = r_prepend;
    assign o_row_phase_out = r_phase_out;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for staircase_code_row_interleaver: random row traffic
// with bursty input, a stalling result side and delay register sweeps.
// Depends on scri_pkg and the staircase_code_row_interleaver RTL.
module tb_top;
    import scri_pkg::*;

    localparam int CLASSES    = 2;
    localparam int PERMS      = 2;
    localparam int TILE       = 2;
    localparam int MAX_DELAY  = 7;
    localparam int ROW_W      = CLASSES * TILE;
    localparam int PRE_W      = PERMS * ROW_W;
    localparam int DEPTH      = (1 + MAX_DELAY) * TILE - 1;
    localparam int NUM_DELAYS = CLASSES * PERMS;
    localparam int IDX_W      = f_idx_w(NUM_DELAYS);
    localparam int DLY_W      = f_idx_w(MAX_DELAY + 1);
    localparam int PH_W       = f_idx_w(TILE);
    localparam int RAND_ROWS  = 150;
    localparam int HOLD_LEN   = 80;

    // Delay register map, in the order of the config port indexes.
    typedef enum logic [IDX_W-1:0] {
        DLY_C0_P1,
        DLY_C0_P2,
        DLY_C1_P1,
        DLY_C1_P2
    } t_delay_reg;

    typedef struct packed {
        logic [PRE_W-1:0] prepend;
        logic [PH_W-1:0]  phase;
    } t_row_result;

    // DUT ports; every input starts at a known value.
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_ready;
    logic [ROW_W-1:0]   i_new_row_bits  = '0;
    logic               o_out_valid;
    logic               i_out_ready     = 1'b0;
    logic [PRE_W-1:0]   o_prepend_bits;
    logic [PH_W-1:0]    o_row_phase_out;
    logic               i_cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index     = '0;
    logic [DLY_W-1:0]   i_cfg_wdata     = '0;

    // Predictor state: row history, newest slot, row phase and delay table.
    logic [ROW_W-1:0]   hist_rows [DEPTH];
    int                 hist_head;
    int                 hist_phase;
    logic [DLY_W-1:0]   delay_blk [NUM_DELAYS];

    // Rows waiting to be offered and results still owed by the block.
    logic [ROW_W-1:0]   rows_to_send    [$];
    t_row_result        pending_results [$];

    int                 err_count   = 0;
    bit                 row_taken   = 1'b0;
    int                 gap_left    = 0;
    int                 burst_left  = 8;
    logic [15:0]        stall_pattern = 16'hFFFF;
    int                 pat_pos     = 0;
    int                 hold_left   = 0;
    bit                 hold_req    = 1'b0;

    staircase_code_row_interleaver #(
        .CLASSES   (CLASSES),
        .PERMS     (PERMS),
        .TILE      (TILE),
        .MAX_DELAY (MAX_DELAY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_new_row_bits  (i_new_row_bits),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_prepend_bits  (o_prepend_bits),
        .o_row_phase_out (o_row_phase_out),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gather the prepend bits for one new row at the current phase, then
    // advance the newest slot and store the row there.
    function automatic void gather_and_store(input logic [ROW_W-1:0] row,
                                             output t_row_result res);
        int r, perm, b, c, cls, lookback, slot, col;
        res.prepend = '0;
        for (int j = 0; j < PRE_W; j++) begin
            r    = j % ROW_W;
            perm = PERMS - j / ROW_W;
            b    = r % TILE;
            c    = r / TILE;
            cls  = CLASSES - 1 - c;
            // Lookback 1 is the newest row; zero or negative lookbacks and
            // ones past the depth both wrap around the history.
            lookback = int'(delay_blk[cls * PERMS + perm - 1]) * TILE - b + hist_phase;
            slot = (hist_head + 1 - lookback) % DEPTH;
            if (slot < 0) begin
                slot += DEPTH;
            end
            col = c * TILE + (hist_phase + (perm - 1) * b) % TILE;
            res.prepend[j] = hist_rows[slot][col];
        end
        res.phase  = hist_phase[PH_W-1:0];
        hist_head  = (hist_head + 1) % DEPTH;
        hist_rows[hist_head] = row;
        hist_phase = (hist_phase + 1) % TILE;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    // Write all four delay registers, one per cycle, and mirror each write
    // into the predictor at the edge that applies it.
    task automatic set_delays(input logic [DLY_W-1:0] d0, d1, d2, d3);
        logic [DLY_W-1:0] vals [NUM_DELAYS];
        t_delay_reg       which;
        vals  = '{d0, d1, d2, d3};
        which = which.first();
        repeat (NUM_DELAYS) begin
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= which;
            i_cfg_wdata <= vals[which];
            @(posedge i_clk);
            delay_blk[which] = vals[which];
            which = which.next();
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_random_rows(input int count);
        repeat (count) begin
            rows_to_send.push_back(ROW_W'($urandom));
        end
    endtask

    // Block until every row went in and every result came out, sampled at the
    // rising edge where valid and the output register are stable, then let
    // things settle before touching the config.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (rows_to_send.size() != 0 || i_in_valid || o_out_valid ||
                   pending_results.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // Input driver: bursts of random length separated by random gaps.
    // Hold valid and the row steady until the transfer happens.
    always @(negedge i_clk) begin
        if (!i_in_valid || row_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (rows_to_send.size() > 0) begin
                i_in_valid     <= 1'b1;
                i_new_row_bits <= rows_to_send.pop_front();
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side: follow a rotating 16-bit ready pattern, sometimes all
    // ones, and now and then hold off for a long stretch to back up the block.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= stall_pattern[pat_pos];
            if (pat_pos == 15) begin
                pat_pos = 0;
                stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                if ($urandom_range(0, 39) == 0) begin
                    hold_left = $urandom_range(30, 90);
                end
            end else begin
                pat_pos = pat_pos + 1;
            end
        end
    end

    // Monitor: check the result transfer against the oldest expectation first,
    // then predict the row transfer of the same edge.
    always @(posedge i_clk) begin
        t_row_result want;
        t_row_result seen;
        row_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.prepend = o_prepend_bits;
            seen.phase   = o_row_phase_out;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result prepend=%h phase=%0d",
                                          seen.prepend, seen.phase));
            end else begin
                want = pending_results.pop_front();
                if (seen.prepend !== want.prepend) begin
                    report_mismatch($sformatf("prepend_bits got %h want %h",
                                              seen.prepend, want.prepend));
                end
                if (seen.phase !== want.phase) begin
                    report_mismatch($sformatf("row_phase_out got %0d want %0d",
                                              seen.phase, want.phase));
                end
            end
        end
        if (row_taken) begin
            gather_and_store(i_new_row_bits, want);
            pending_results.push_back(want);
        end
    end

    // Stimulus sequence.
    initial begin
        // Mirror the reset state: cleared history, default delays.
        foreach (hist_rows[k]) begin
            hist_rows[k] = '0;
        end
        hist_head  = 0;
        hist_phase = 0;
        delay_blk  = '{3'd2, 3'd7, 3'd3, 3'd4};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default delays: all-zero and all-one rows, then walking ones and zeros and
        // two-bit patterns; the long default delay reaches back to the oldest row.
        rows_to_send = {4'h0, 4'hF, 4'h1, 4'h2, 4'h4, 4'h8, 4'hE, 4'hD,
                        4'hB, 4'h7, 4'h5, 4'hA, 4'h3, 4'hC, 4'h6, 4'h9};
        wait_idle();

        // Zero delays: lookbacks of zero or less wrap to the oldest rows.
        set_delays(3'd0, 3'd0, 3'd0, 3'd0);
        rows_to_send = {4'hF, 4'h0, 4'hF, 4'h0, 4'h9, 4'h6, 4'hA, 4'h5};
        queue_random_rows(RAND_ROWS);
        wait_idle();

        // Maximum delays: lookbacks up to the history depth.
        // Hold the result side off so the block backs up and stalls its input.
        set_delays(3'd7, 3'd7, 3'd7, 3'd7);
        queue_random_rows(RAND_ROWS);
        @(posedge i_clk);
        hold_req = 1'b1;
        wait_idle();

        // Mixed extremes in both arrangements.
        set_delays(3'd0, 3'd7, 3'd7, 3'd0);
        queue_random_rows(RAND_ROWS);
        wait_idle();

        set_delays(3'd7, 3'd0, 3'd0, 3'd7);
        queue_random_rows(RAND_ROWS);
        wait_idle();

        // Random settings.
        repeat (3) begin
            set_delays(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            queue_random_rows(RAND_ROWS);
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("staircase_code_row_interleaver regression: pass");
        end else begin
            $display("staircase_code_row_interleaver regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("staircase_code_row_interleaver regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/scri_pkg.sv
rtl/scri_tap.sv
rtl/scri_cell.sv
rtl/staircase_code_row_interleaver.sv
tb/tb_top.sv
